### rtl/oli_pkg.sv
// Shared types and codes for the ordered list block.
package oli_pkg;

  // Field widths fixed by the item format
  localparam int WORD_W = 32;
  localparam int POS_W  = 6;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;

  // Entries OR-ed together in one group of the read tree
  localparam int GRP_SIZE = 8;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_READ   = 2'd2,
    REQ_DELETE = 2'd3
  } req_t;

  // Status codes (value 3 is unused)
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

  // What each cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

  // Control broadcast to every cell
  typedef struct packed {
    cell_op_t op;
    logic     rd_en;
  } cell_ctl_t;

  // Control sequencer states
  typedef enum logic {
    S_IDLE,
    S_REDUCE
  } state_t;

endpackage

### rtl/oli_cell.sv
// One list entry: holds a word and trades it with its neighbors on insert or delete.
module oli_cell #(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  oli_pkg::cell_ctl_t        ctl,
  input  logic [IDX_W-1:0]          pos,
  input  logic [oli_pkg::WORD_W-1:0] word_in,
  input  logic [oli_pkg::WORD_W-1:0] left_value,
  input  logic [oli_pkg::WORD_W-1:0] right_value,
  output logic [oli_pkg::WORD_W-1:0] value,
  output logic [oli_pkg::WORD_W-1:0] sel_value
);
  import oli_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic at_pos;
  logic past_pos;
  logic [WORD_W-1:0] value_next;

  assign at_pos   = (MY_IDX == pos);
  assign past_pos = (MY_IDX > pos);

  // Shift up above the insert point, shift down from the delete point
  always_comb begin
    value_next = value;
    case (ctl.op)
      CELL_INSERT: begin
        if (at_pos) value_next = word_in;
        else if (past_pos) value_next = left_value;
      end
      CELL_DELETE: begin
        if (at_pos || past_pos) value_next = right_value;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // Word offered to the read tree, zero unless this cell is addressed
  assign sel_value = (ctl.rd_en && at_pos) ? value : '0;

endmodule

### rtl/ordered_list_insert_delete.sv
// Top level of the ordered list: request decode, row of entry cells, read tree, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | to block  | in_valid / in_ready  | req_type, position, word_in
//  out     | from block| out_valid / out_ready| word_out, status, fill_count
//
// For each item the cells shift and the addressed word is caught in group
// registers on the accept edge, then the group OR lands in the result register.
// The next item is accepted while a finished result still waits to be taken.
// Reset clears the count and the control; entry contents stay unknown until written.
// A stalled output holds the second step until the result register frees up.
module ordered_list_insert_delete #(
  parameter int CAPACITY = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [oli_pkg::REQ_W-1:0]             req_type,
  input  logic [oli_pkg::POS_W-1:0]             position,
  input  logic signed [oli_pkg::WORD_W-1:0]     word_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [oli_pkg::WORD_W-1:0]     word_out,
  output logic [oli_pkg::STAT_W-1:0]            status,
  output logic [$clog2(CAPACITY+1)-1:0]         fill_count
);
  import oli_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int NGRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  state_t state, state_next;
  logic   accept;
  logic   load_out;

  logic [CNT_W-1:0]  used_count;
  logic [CNT_W-1:0]  count_next;
  logic [STAT_W-1:0] stat_next;
  logic [STAT_W-1:0] pend_stat;
  logic [CNT_W-1:0]  pend_count;
  cell_ctl_t         ctl;
  logic [IDX_W-1:0]  cell_pos;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;

  logic [WORD_W-1:0] cell_value [CAPACITY];
  logic [WORD_W-1:0] cell_sel   [CAPACITY];
  logic [WORD_W-1:0] grp_or_next [NGRP];
  logic [WORD_W-1:0] grp_or      [NGRP];
  logic [WORD_W-1:0] read_word;

  assign accept  = in_valid && in_ready;
  assign pos_ext = CMP_W'(position);
  assign cnt_ext = CMP_W'(used_count);

  // Request decode: status, cell control and new count
  always_comb begin
    ctl.op     = CELL_HOLD;
    ctl.rd_en  = 1'b0;
    cell_pos   = pos_ext[IDX_W-1:0];
    stat_next  = ST_OK;
    count_next = used_count;
    if (req_type == REQ_APPEND || req_type == REQ_INSERT) begin
      if (used_count == FULL_CNT) begin
        stat_next = ST_FULL;
      end else if (req_type == REQ_INSERT && pos_ext > cnt_ext) begin
        stat_next = ST_BAD;
      end else begin
        ctl.op     = accept ? CELL_INSERT : CELL_HOLD;
        count_next = used_count + 1'b1;
        if (req_type == REQ_APPEND) cell_pos = cnt_ext[IDX_W-1:0];
      end
    end else begin
      if (pos_ext >= cnt_ext) begin
        stat_next = ST_BAD;
      end else begin
        ctl.rd_en = accept;
        if (req_type == REQ_DELETE) begin
          ctl.op     = accept ? CELL_DELETE : CELL_HOLD;
          count_next = used_count - 1'b1;
        end
      end
    end
  end

  // Row of entry cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] left_v;
    logic [WORD_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_value[i];
    end else begin : g_mid_r
      assign right_v = cell_value[i+1];
    end
    oli_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .pos         (cell_pos),
      .word_in     (word_in),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_value[i]),
      .sel_value   (cell_sel[i])
    );
  end

  // First level of the read tree: OR within each group of cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_or_next[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < CAPACITY) begin
          grp_or_next[g] = grp_or_next[g] | cell_sel[g * GRP_SIZE + k];
        end
      end
    end
  end

  // Second level: OR across the group registers
  always_comb begin
    read_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      read_word = read_word | grp_or[g];
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_REDUCE;
      end
      S_REDUCE: begin
        load_out = !out_valid || out_ready;
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Count and valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) used_count <= count_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Pending result fields and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_stat  <= stat_next;
      pend_count <= count_next;
      for (int g = 0; g < NGRP; g++) begin
        grp_or[g] <= grp_or_next[g];
      end
    end
    if (load_out) begin
      word_out   <= read_word;
      status     <= pend_stat;
      fill_count <= pend_count;
    end
  end

endmodule
